### src/itmb_pkg.sv
// Shared types and constants of the id-tagged message buffer.
package itmb_pkg;

  localparam logic [7:0] ID_LIMIT = 8'd9;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_REJECT    = 2'd1;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd2;

  typedef enum logic [1:0] {
    K_ADD,
    K_REJECT,
    K_READ
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  id;
    logic [6:0]  len;
    logic [7:0]  data;
    logic        last;
  } item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVICT,
    S_WRITE,
    S_SCAN,
    S_FOUND,
    S_REQ,
    S_DATA,
    S_REPLY
  } state_t;

endpackage

### src/id_tagged_message_buffer_top.sv
// Top level of the id-tagged message buffer.
// Holds up to SLOTS messages of up to MAX_LEN bytes, tagged by service id 0 to 9, in
// arrival order. Incoming words pass through a two-word queue into a sequencer that
// owns all message state and a single payload RAM. Each word is taken from the
// queue, then: an add byte is written, after the oldest message is evicted when all
// slots are full, and the last word of a message brings its commit or reject result;
// a read inspects held messages oldest first (up to SLOTS), unlinks the hit, then
// sends each payload byte, fetched from the RAM's registered read port before it
// enters the output register. A read that misses, or that hits an empty message,
// gets a single reply. Results wait in that register while the queue takes input
// until it is full.
module id_tagged_message_buffer_top #(
  parameter int SLOTS   = 8,
  parameter int MAX_LEN = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       action,
  input  logic [7:0] service_id,
  input  logic [6:0] msg_length,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] status,
  output logic [7:0] out_id,
  output logic [6:0] out_length,
  output logic [7:0] out_byte,
  output logic       last_out
);
  import itmb_pkg::*;

  logic  q_valid;
  item_t q_item;
  logic  q_pop;

  itmb_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .action    (action),
    .service_id(service_id),
    .msg_length(msg_length),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop)
  );

  itmb_back #(
    .SLOTS  (SLOTS),
    .MAX_LEN(MAX_LEN)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .out_id    (out_id),
    .out_length(out_length),
    .out_byte  (out_byte),
    .last_out  (last_out)
  );

endmodule

### src/itmb_ram.sv
// Generic single write port RAM with a registered read port.
module itmb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### src/itmb_front.sv
// Front end: classifies incoming words and queues them for the back end.
module itmb_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic          action,
  input  logic [7:0]    service_id,
  input  logic [6:0]    msg_length,
  input  logic [7:0]    data_byte,
  input  logic          last_byte,
  output logic          q_valid,
  output itmb_pkg::item_t q_item,
  input  logic          q_pop
);
  import itmb_pkg::*;

  item_t      mem [2];
  item_t      word;
  logic       wptr;
  logic       rptr;
  logic [1:0] count;
  logic       push;

  always_comb begin
    word.id   = service_id;
    word.len  = msg_length;
    word.data = data_byte;
    word.last = last_byte;
    if (action) begin
      word.kind = K_READ;
    end else if (service_id > ID_LIMIT) begin
      word.kind = K_REJECT;
    end else begin
      word.kind = K_ADD;
    end
  end

  assign in_stall = (count == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != 2'd0);
  assign q_item   = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= !wptr;
      end
      if (q_pop) begin
        rptr <= !rptr;
      end
      count <= count + 2'(push) - 2'(q_pop);
    end
  end

endmodule

### src/itmb_back.sv
// Back end: holds the messages, serves adds and reads, and drives the result port.
module itmb_back #(
  parameter int SLOTS   = 8,
  parameter int MAX_LEN = 64
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  input  itmb_pkg::item_t q_item,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [1:0]      status,
  output logic [7:0]      out_id,
  output logic [6:0]      out_length,
  output logic [7:0]      out_byte,
  output logic            last_out
);
  import itmb_pkg::*;

  localparam int SW = $clog2(SLOTS);
  localparam int HW = $clog2(SLOTS + 1);
  localparam int FW = $clog2(MAX_LEN + 1);
  localparam int LW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int KW = LW + 1;
  localparam int AW = SW + LW;

  state_t          state;
  state_t          state_next;
  item_t           item;
  logic [HW-1:0]   held;
  logic [FW-1:0]   fill;
  logic [SW-1:0]   rank [SLOTS];
  logic [3:0]      tag  [SLOTS];
  logic [FW-1:0]   slen [SLOTS];
  logic [SW-1:0]   scan_i;
  logic [SW-1:0]   found_slot;
  logic [FW-1:0]   rd_len;
  logic [LW-1:0]   k;
  logic [1:0]      res_status;

  logic            out_free;
  logic            full;
  logic            room;
  logic            commit;
  logic            scan_end;
  logic            k_last;
  logic [SW-1:0]   build_slot;
  logic            hit_any;
  logic [SW-1:0]   hit_slot;
  logic [FW-1:0]   hit_len;
  logic [FW-1:0]   cap_len;

  logic            ram_we;
  logic            ram_re;
  logic [AW-1:0]   ram_waddr;
  logic [AW-1:0]   ram_raddr;
  logic [7:0]      ram_rdata;
  logic            rm_en;
  logic [SW-1:0]   rm_pos;
  logic            load_byte;
  logic            load_reply;

  assign out_free = !out_valid || !out_stall;
  assign full     = (held == HW'(SLOTS));
  assign room     = (fill < FW'(MAX_LEN));
  assign commit   = item.last;
  assign scan_end = (HW'(scan_i) + HW'(1) == held);
  assign k_last   = (KW'(k) + KW'(1) == KW'(rd_len));
  assign cap_len  = (item.len > 7'(MAX_LEN)) ? FW'(MAX_LEN) : FW'(item.len);

  always_comb begin
    build_slot = '0;
    hit_any    = 1'b0;
    hit_slot   = '0;
    hit_len    = '0;
    for (int s = 0; s < SLOTS; s++) begin
      if (HW'(rank[s]) == held) begin
        build_slot = SW'(s);
      end
      if (rank[s] == scan_i && {4'b0000, tag[s]} == item.id) begin
        hit_any  = 1'b1;
        hit_slot = SW'(s);
        hit_len  = slen[s];
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (q_valid) begin
          case (q_item.kind)
            K_ADD:    state_next = full ? S_EVICT : S_WRITE;
            K_REJECT: state_next = q_item.last ? S_REPLY : S_IDLE;
            K_READ:   state_next = (held == '0) ? S_REPLY : S_SCAN;
            default:  state_next = S_IDLE;
          endcase
        end
      end
      S_EVICT: state_next = S_WRITE;
      S_WRITE: state_next = commit ? S_REPLY : S_IDLE;
      S_SCAN: begin
        if (hit_any) begin
          state_next = S_FOUND;
        end else if (scan_end) begin
          state_next = S_REPLY;
        end
      end
      S_FOUND: state_next = (rd_len == '0) ? S_REPLY : S_REQ;
      S_REQ:   state_next = S_DATA;
      S_DATA: begin
        if (out_free) begin
          state_next = k_last ? S_IDLE : S_REQ;
        end
      end
      S_REPLY: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    q_pop      = 1'b0;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    rm_en      = 1'b0;
    rm_pos     = '0;
    load_byte  = 1'b0;
    load_reply = 1'b0;
    ram_waddr  = {build_slot, fill[LW-1:0]};
    ram_raddr  = {found_slot, k};
    case (state)
      S_IDLE:  q_pop = q_valid;
      S_EVICT: rm_en = 1'b1;
      S_WRITE: ram_we = room;
      S_FOUND: begin
        rm_en  = 1'b1;
        rm_pos = scan_i;
      end
      S_REQ:   ram_re = 1'b1;
      S_DATA:  load_byte = out_free;
      S_REPLY: load_reply = out_free;
      default: q_pop = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      held  <= '0;
      fill  <= '0;
      for (int s = 0; s < SLOTS; s++) begin
        rank[s] <= SW'(s);
      end
    end else begin
      state <= state_next;
      if (rm_en) begin
        for (int s = 0; s < SLOTS; s++) begin
          if (rank[s] == rm_pos) begin
            rank[s] <= SW'(held - HW'(1));
          end else if (rank[s] > rm_pos && HW'(rank[s]) < held) begin
            rank[s] <= rank[s] - SW'(1);
          end
        end
        held <= held - HW'(1);
      end
      if (state == S_IDLE && q_valid && q_item.kind != K_ADD) begin
        fill <= '0;
      end
      if (state == S_WRITE) begin
        if (commit) begin
          fill <= '0;
          held <= held + HW'(1);
        end else if (room) begin
          fill <= fill + FW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      item   <= q_item;
      scan_i <= '0;
      if (q_item.kind == K_REJECT) begin
        res_status <= STAT_REJECT;
      end else if (q_item.kind == K_READ) begin
        res_status <= STAT_NOT_FOUND;
      end else begin
        res_status <= STAT_OK;
      end
    end
    if (state == S_WRITE && commit) begin
      tag[build_slot]  <= item.id[3:0];
      slen[build_slot] <= cap_len;
    end
    if (state == S_SCAN) begin
      if (hit_any) begin
        found_slot <= hit_slot;
        rd_len     <= hit_len;
        res_status <= STAT_OK;
      end else begin
        scan_i <= scan_i + SW'(1);
      end
    end
    if (state == S_FOUND) begin
      k <= '0;
    end
    if (load_byte) begin
      k <= k + LW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_byte || load_reply) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_byte) begin
      status     <= STAT_OK;
      out_id     <= item.id;
      out_length <= 7'(rd_len);
      out_byte   <= ram_rdata;
      last_out   <= k_last;
    end else if (load_reply) begin
      status     <= res_status;
      out_id     <= item.id;
      out_length <= 7'd0;
      out_byte   <= 8'd0;
      last_out   <= 1'b1;
    end
  end

  itmb_ram #(
    .WIDTH(8),
    .DEPTH(SLOTS * (2 ** LW))
  ) u_payload (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(item.data),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

endmodule

### src/itmb_checker.sv
// Port-level assertions for the id-tagged message buffer, bound to the top level.
module itmb_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] status,
  input logic [7:0] out_id,
  input logic [6:0] out_length,
  input logic [7:0] out_byte,
  input logic       last_out
);
  import itmb_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(last_out))
    else $error("stalled result word changed");

  a_short: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != STAT_OK |-> last_out && out_length == 7'd0 && out_byte == 8'd0)
    else $error("error result is not a single empty word");

  a_reject: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STAT_REJECT |-> out_id > ID_LIMIT)
    else $error("valid id reported as rejected");

  a_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STAT_OK && out_length == 7'd0 |-> last_out && out_byte == 8'd0)
    else $error("empty message result is not a single word");

endmodule

bind id_tagged_message_buffer_top itmb_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .status    (status),
  .out_id    (out_id),
  .out_length(out_length),
  .out_byte  (out_byte),
  .last_out  (last_out)
);

### tb/tb.sv
// Testbench of the id-tagged message buffer with an in-order predictor and scoreboard.
module tb;
  import itmb_pkg::*;

  localparam int SLOTS    = 8;
  localparam int MAX_LEN  = 64;
  localparam int LIMIT    = 400000;
  localparam int HOLD_LEN = 400;

  typedef struct {
    logic       action;
    logic [7:0] id;
    logic [6:0] len;
    logic [7:0] data;
    logic       last;
  } word_t;

  typedef struct {
    logic [1:0] status;
    logic [7:0] id;
    logic [6:0] len;
    logic [7:0] data;
    logic       last;
  } reply_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic       action = 1'b0;
  logic [7:0] service_id = '0;
  logic [6:0] msg_length = '0;
  logic [7:0] data_byte = '0;
  logic       last_byte = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b1;
  logic [1:0] status;
  logic [7:0] out_id;
  logic [6:0] out_length;
  logic [7:0] out_byte;
  logic       last_out;

  word_t  pending_words[$];
  reply_t expected_replies[$];
  int     send_idle_pct = 16;
  int     recv_idle_pct = 67;
  int     errors = 0;
  int     words_sent = 0;
  int     replies_seen = 0;
  int     cycle = 0;
  logic   hold_go = 1'b0;
  int     hold_cycles = 0;
  logic   hold_off;

  // Mirror of the buffer contents.
  logic [7:0] store_bytes[SLOTS*MAX_LEN];
  logic [3:0] slot_id[SLOTS];
  logic [6:0] slot_len[SLOTS];
  int         written_to[SLOTS];
  int         order[SLOTS];
  int         held;
  int         cursor;

  id_tagged_message_buffer_top #(.SLOTS(SLOTS), .MAX_LEN(MAX_LEN)) i_dut (.*);

  always #1 clk = ~clk;

  function automatic void unlink(int pos);
    int s;
    s = order[pos];
    for (int i = pos; i + 1 < held; i++) order[i] = order[i + 1];
    order[held - 1] = s;
    held--;
  endfunction

  function automatic void expect_reply(logic [1:0] st, logic [7:0] id, logic [6:0] len,
                                       logic [7:0] d, logic l);
    reply_t r;
    r.status = st;
    r.id = id;
    r.len = len;
    r.data = d;
    r.last = l;
    expected_replies.push_back(r);
  endfunction

  // Updates the mirror for one word; a commit length is trimmed so no unwritten byte is read.
  function automatic void predict_word(ref word_t w);
    int s;
    int n;
    if (w.action == 1'b0) begin
      if (w.id > ID_LIMIT) begin
        cursor = 0;
        if (w.last) expect_reply(STAT_REJECT, w.id, 7'd0, 8'd0, 1'b1);
        return;
      end
      if (cursor == 0 && held >= SLOTS) unlink(0);
      s = order[held];
      if (cursor < MAX_LEN) begin
        store_bytes[s*MAX_LEN + cursor] = w.data;
        cursor++;
        if (cursor > written_to[s]) written_to[s] = cursor;
      end
      if (!w.last) return;
      n = (int'(w.len) > MAX_LEN) ? MAX_LEN : int'(w.len);
      if (n > written_to[s]) begin
        n = written_to[s];
        w.len = 7'(n);
      end
      slot_id[s] = w.id[3:0];
      slot_len[s] = 7'(n);
      held++;
      cursor = 0;
      expect_reply(STAT_OK, w.id, 7'd0, 8'd0, 1'b1);
    end else begin
      cursor = 0;
      for (int i = 0; i < held; i++) begin
        s = order[i];
        if ({4'd0, slot_id[s]} == w.id) begin
          n = int'(slot_len[s]);
          unlink(i);
          if (n == 0) expect_reply(STAT_OK, w.id, 7'd0, 8'd0, 1'b1);
          for (int k = 0; k < n; k++)
            expect_reply(STAT_OK, w.id, 7'(n), store_bytes[s*MAX_LEN + k], k == n - 1);
          return;
        end
      end
      expect_reply(STAT_NOT_FOUND, w.id, 7'd0, 8'd0, 1'b1);
    end
  endfunction

  function automatic void queue_word(logic a, logic [7:0] id, logic [6:0] len,
                                     logic [7:0] d, logic l);
    word_t w;
    w.action = a;
    w.id = id;
    w.len = len;
    w.data = d;
    w.last = l;
    predict_word(w);
    pending_words.push_back(w);
  endfunction

  // Sends a message of nbytes bytes; the requested length is trimmed to bytes held.
  function automatic void queue_message(logic [7:0] id, int nbytes, logic [6:0] len);
    for (int i = 0; i < nbytes; i++)
      queue_word(1'b0, id, len, 8'($urandom_range(0, 255)), i == nbytes - 1);
  endfunction

  function automatic void queue_read(logic [7:0] id);
    queue_word(1'b1, id, 7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)),
               1'($urandom_range(0, 1)));
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch in %s: got %0d, expected %0d (cycle %0d)", what, got, want, cycle);
    errors++;
  endtask

  task automatic drain;
    while (pending_words.size() != 0 || in_valid || expected_replies.size() != 0)
      @(posedge clk);
  endtask

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > LIMIT) begin
      $display("timeout with %0d replies outstanding", expected_replies.size());
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (hold_go && hold_cycles < HOLD_LEN) hold_cycles <= hold_cycles + 1;
  end

  assign hold_off = hold_go && (hold_cycles < HOLD_LEN);

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) words_sent <= words_sent + 1;
      if (pending_words.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        word_t w;
        w = pending_words.pop_front();
        action <= w.action;
        service_id <= w.id;
        msg_length <= w.len;
        data_byte <= w.data;
        last_byte <= w.last;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      reply_t r;
      replies_seen <= replies_seen + 1;
      if (expected_replies.size() == 0) begin
        report_mismatch("unexpected word", 1, 0);
      end else begin
        r = expected_replies.pop_front();
        if (status !== r.status) report_mismatch("status", int'(status), int'(r.status));
        if (out_id !== r.id) report_mismatch("out_id", int'(out_id), int'(r.id));
        if (out_length !== r.len)
          report_mismatch("out_length", int'(out_length), int'(r.len));
        if (out_byte !== r.data) report_mismatch("out_byte", int'(out_byte), int'(r.data));
        if (last_out !== r.last) report_mismatch("last_out", int'(last_out), int'(r.last));
      end
    end
    out_stall <= rst || hold_off || ($urandom_range(0, 99) < recv_idle_pct);
  end

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      order[i] = i;
      written_to[i] = 0;
    end
    held = 0;
    cursor = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: extremes of ids and bytes, rejects, misses, zero length, eviction.
    queue_word(1'b0, 8'd0, 7'd1, 8'h00, 1'b1);
    queue_word(1'b0, 8'd9, 7'd2, 8'hff, 1'b0);
    queue_word(1'b0, 8'd9, 7'd2, 8'h5a, 1'b1);
    queue_word(1'b0, 8'd10, 7'd0, 8'h12, 1'b1);
    queue_word(1'b0, 8'd255, 7'd127, 8'hff, 1'b0);
    queue_word(1'b0, 8'd3, 7'd0, 8'h77, 1'b1);
    queue_read(8'd4);
    queue_read(8'd255);
    queue_read(8'd3);
    queue_read(8'd9);
    queue_word(1'b0, 8'd5, 7'd3, 8'h11, 1'b0);
    queue_read(8'd0);
    queue_message(8'd7, 65, 7'd64);
    for (int i = 0; i < 9; i++) queue_message(8'(i), 1, 7'd1);
    queue_read(8'd0);
    queue_read(8'd7);
    drain();

    // Random: mostly whole messages and reads, some broken words; long hold in phase two.
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 16 : (phase == 1) ? 67 : 0;
      recv_idle_pct = (phase == 0) ? 67 : (phase == 1) ? 16 : 0;
      if (phase == 1) begin
        for (int i = 0; i < 4; i++) queue_read(8'(i));
        hold_go = 1'b1;
      end
      for (int m = 0; m < 4; m++) begin
        int kind;
        int n;
        kind = $urandom_range(0, 9);
        n = $urandom_range(1, 4);
        if (kind < 5)
          queue_message(8'($urandom_range(0, 9)), n,
                        ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 64)) : 7'(n));
        else if (kind < 8)
          queue_read(8'($urandom_range(0, 11)));
        else
          queue_word(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                     7'($urandom_range(0, 64)), 8'($urandom_range(0, 255)),
                     1'($urandom_range(0, 1)));
      end
      drain();
    end

    repeat (300) @(posedge clk);
    $display("covered %0d input words and %0d output words over three idle patterns",
             words_sent, replies_seen);
    $display("including a %0d-cycle receiver hold that backed up the input", HOLD_LEN);
    if (errors == 0 && expected_replies.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
